### hdl/sorted_key_value_node_defines.svh
// Assertion macros shared by the sorted key/value node RTL.
`ifndef SORTED_KEY_VALUE_NODE_DEFINES_SVH
`define SORTED_KEY_VALUE_NODE_DEFINES_SVH
`ifndef ASSERT_OFF
// Checks that a condition holds at every clock edge outside reset.
`define SKVN_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);
// Checks that a consequent holds in the cycle after its antecedent.
`define SKVN_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`else
`define SKVN_ASSERT(lbl, prop, msg)
`define SKVN_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

### hdl/skvn_pkg.sv
// Types, constants and helpers for the sorted key/value node.
package skvn_pkg;

   localparam int CAPACITY_DEF = 19;
   localparam int KEY_W        = 64;
   localparam int VAL_W        = 64;

   // Request command codes.
   typedef enum logic [1:0] {
      CMD_INSERT = 2'd0,
      CMD_SEARCH = 2'd1,
      CMD_DUMP   = 2'd2,
      CMD_NONE   = 2'd3
   } cmd_type;

   // Response status codes.
   typedef enum logic [2:0] {
      ST_INSERTED = 3'd0,
      ST_FULL     = 3'd1,
      ST_FOUND    = 3'd2,
      ST_NOTFOUND = 3'd3,
      ST_DUMP     = 3'd4,
      ST_EMPTY    = 3'd5
   } status_type;

   // Controller states.
   typedef enum logic {
      S_IDLE   = 1'b0,
      S_STREAM = 1'b1
   } state_type;

   // Controls broadcast to every cell of the chain.
   typedef struct packed {
      logic ins_en;
      logic rd_load;
      logic rd_shift;
   } cell_ctrl_type;

   // True when pair (ka, va) sorts strictly after pair (kb, vb).
   function automatic logic pair_after(input logic [KEY_W-1:0] ka,
                                       input logic [VAL_W-1:0] va,
                                       input logic [KEY_W-1:0] kb,
                                       input logic [VAL_W-1:0] vb);
      logic res;
      if (ka != kb) begin
         res = (ka > kb);
      end else begin
         res = (va > vb);
      end
      return res;
   endfunction

endpackage

### hdl/skvn_cell.sv
// One cell of the sorted chain: a stored pair plus a read stage.
module skvn_cell
   import skvn_pkg::*;
(
   input  logic                clock,
   input  cell_ctrl_type       ctrl,
   input  logic                occupied,
   input  logic [KEY_W-1:0]    new_key,
   input  logic [VAL_W-1:0]    new_value,
   input  logic                prev_after,
   input  logic [KEY_W-1:0]    prev_key,
   input  logic [VAL_W-1:0]    prev_value,
   input  logic [KEY_W-1:0]    next_rd_key,
   input  logic [VAL_W-1:0]    next_rd_value,
   output logic                after,
   output logic [KEY_W-1:0]    key,
   output logic [VAL_W-1:0]    value,
   output logic [KEY_W-1:0]    rd_key,
   output logic [VAL_W-1:0]    rd_value
);

   logic [KEY_W-1:0] key_ff, key_in;
   logic [VAL_W-1:0] value_ff, value_in;
   logic [KEY_W-1:0] rd_key_ff, rd_key_in;
   logic [VAL_W-1:0] rd_value_ff, rd_value_in;

   // The new pair belongs at or before this cell when the cell is empty or sorts after it.
   assign after = !occupied || pair_after(key_ff, value_ff, new_key, new_value);

   // The first cell past the insert point takes the new pair; later ones take the left neighbor.
   always_comb begin
      key_in   = key_ff;
      value_in = value_ff;
      if (ctrl.ins_en && after) begin
         if (prev_after) begin
            key_in   = prev_key;
            value_in = prev_value;
         end else begin
            key_in   = new_key;
            value_in = new_value;
         end
      end
   end

   // The read stage copies the pair, then moves toward the head of the chain.
   always_comb begin
      rd_key_in   = rd_key_ff;
      rd_value_in = rd_value_ff;
      if (ctrl.rd_load) begin
         rd_key_in   = key_ff;
         rd_value_in = value_ff;
      end else if (ctrl.rd_shift) begin
         rd_key_in   = next_rd_key;
         rd_value_in = next_rd_value;
      end
   end

   always_ff @(posedge clock) begin
      key_ff      <= key_in;
      value_ff    <= value_in;
      rd_key_ff   <= rd_key_in;
      rd_value_ff <= rd_value_in;
   end

   assign key      = key_ff;
   assign value    = value_ff;
   assign rd_key   = rd_key_ff;
   assign rd_value = rd_value_ff;

endmodule

### hdl/sorted_key_value_node.sv
// Top level of the sorted key/value node: controller and chain of cells.
//
//   Channel   Handshake              Payload
//   request   start / busy           req_cmd, req_key, req_value
//   response  rsp_valid (strobe)     rsp_status, rsp_out_key, rsp_out_value, rsp_last
//
// Inserts, rejected inserts and requests on an empty table keep busy low, and the
// registered response shows in the cycle after the request; an unused command
// gives none. A search walks the stored pairs from the head of the read chain, one
// per cycle, and holds busy until the key matches or all N stored pairs are seen;
// a dump emits all N pairs, one per cycle. Reset empties the table at once, no sweep.
// The receiver cannot stall: each response is shown for exactly one cycle.
`include "sorted_key_value_node_defines.svh"
module sorted_key_value_node
   import skvn_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEF
)
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [1:0]          req_cmd,
   input  logic [KEY_W-1:0]    req_key,
   input  logic [VAL_W-1:0]    req_value,
   output logic                rsp_valid,
   output logic [2:0]          rsp_status,
   output logic [KEY_W-1:0]    rsp_out_key,
   output logic [VAL_W-1:0]    rsp_out_value,
   output logic                rsp_last
);

   localparam int CNT_W = $clog2(CAPACITY + 1);

   state_type           state_ff, state_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [CNT_W-1:0]    remain_ff, remain_in;
   cmd_type             mode_ff, mode_in;
   logic [KEY_W-1:0]    skey_ff, skey_in;
   logic                rsp_valid_ff, rsp_valid_in;
   status_type          rsp_status_ff, rsp_status_in;
   logic [KEY_W-1:0]    rsp_key_ff, rsp_key_in;
   logic [VAL_W-1:0]    rsp_value_ff, rsp_value_in;
   logic                rsp_last_ff, rsp_last_in;

   logic                accept;
   logic                not_full;
   logic                head_match;
   cmd_type             cmd;
   cell_ctrl_type       ctrl;

   logic [CAPACITY:0]   after_chain;
   logic [KEY_W-1:0]    cell_key   [CAPACITY];
   logic [VAL_W-1:0]    cell_value [CAPACITY];
   logic [KEY_W-1:0]    rd_key     [CAPACITY+1];
   logic [VAL_W-1:0]    rd_value   [CAPACITY+1];

   assign cmd        = cmd_type'(req_cmd);
   assign busy       = (state_ff == S_STREAM);
   assign accept     = start && !busy;
   assign not_full   = (count_ff < CNT_W'(CAPACITY));
   assign head_match = (rd_key[0] == skey_ff);

   // Chain of cells; the cell past the tail reads back zeros.
   assign after_chain[0]    = 1'b0;
   assign rd_key[CAPACITY]   = '0;
   assign rd_value[CAPACITY] = '0;

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [KEY_W-1:0] prev_key;
      logic [VAL_W-1:0] prev_value;
      if (i == 0) begin : g_head
         assign prev_key   = req_key;
         assign prev_value = req_value;
      end else begin : g_body
         assign prev_key   = cell_key[i-1];
         assign prev_value = cell_value[i-1];
      end
      skvn_cell u_cell (
         .clock         (clock),
         .ctrl          (ctrl),
         .occupied      (CNT_W'(i) < count_ff),
         .new_key       (req_key),
         .new_value     (req_value),
         .prev_after    (after_chain[i]),
         .prev_key      (prev_key),
         .prev_value    (prev_value),
         .next_rd_key   (rd_key[i+1]),
         .next_rd_value (rd_value[i+1]),
         .after         (after_chain[i+1]),
         .key           (cell_key[i]),
         .value         (cell_value[i]),
         .rd_key        (rd_key[i]),
         .rd_value      (rd_value[i])
      );
   end

   // Next-state logic.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept && (count_ff != '0) &&
                (cmd == CMD_SEARCH || cmd == CMD_DUMP)) begin
               state_in = S_STREAM;
            end
         end
         S_STREAM: begin
            if (remain_ff == CNT_W'(1) || (mode_ff == CMD_SEARCH && head_match)) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Output and datapath control logic.
   always_comb begin
      ctrl          = '0;
      count_in      = count_ff;
      remain_in     = remain_ff;
      mode_in       = mode_ff;
      skey_in       = skey_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = ST_INSERTED;
      rsp_key_in    = '0;
      rsp_value_in  = '0;
      rsp_last_in   = 1'b1;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               mode_in   = cmd;
               skey_in   = req_key;
               remain_in = count_ff;
               unique case (cmd)
                  CMD_INSERT: begin
                     rsp_valid_in = 1'b1;
                     if (not_full) begin
                        ctrl.ins_en   = 1'b1;
                        count_in      = count_ff + CNT_W'(1);
                        rsp_status_in = ST_INSERTED;
                     end else begin
                        rsp_status_in = ST_FULL;
                     end
                  end
                  CMD_SEARCH: begin
                     if (count_ff == '0) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = ST_NOTFOUND;
                     end else begin
                        ctrl.rd_load = 1'b1;
                     end
                  end
                  CMD_DUMP: begin
                     if (count_ff == '0) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = ST_EMPTY;
                     end else begin
                        ctrl.rd_load = 1'b1;
                     end
                  end
                  default: begin
                     rsp_valid_in = 1'b0;
                  end
               endcase
            end
         end
         S_STREAM: begin
            ctrl.rd_shift = 1'b1;
            remain_in     = remain_ff - CNT_W'(1);
            if (mode_ff == CMD_DUMP) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_DUMP;
               rsp_key_in    = rd_key[0];
               rsp_value_in  = rd_value[0];
               rsp_last_in   = (remain_ff == CNT_W'(1));
            end else if (head_match) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_FOUND;
               rsp_key_in    = rd_key[0];
               rsp_value_in  = rd_value[0];
            end else if (remain_ff == CNT_W'(1)) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_NOTFOUND;
            end
         end
         default: ctrl = '0;
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         remain_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         remain_ff    <= remain_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      mode_ff       <= mode_in;
      skey_ff       <= skey_in;
      rsp_status_ff <= rsp_status_in;
      rsp_key_ff    <= rsp_key_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_out_key   = rsp_key_ff;
   assign rsp_out_value = rsp_value_ff;
   assign rsp_last      = rsp_last_ff;

   // Assertions.
   `SKVN_ASSERT(a_count_bound, count_ff <= CNT_W'(CAPACITY), "entry count exceeds capacity")
   `SKVN_ASSERT(a_stream_remain, !busy || (remain_ff != '0), "streaming with nothing left")
   `SKVN_ASSERT_NEXT(a_grow, ctrl.ins_en, count_ff == $past(count_ff) + CNT_W'(1), "count stuck")
   `SKVN_ASSERT(a_mid_dump_busy, !(rsp_valid_ff && !rsp_last_ff) || busy, "dump ended early")

endmodule
